>>> rtl/core/resource_lock_pool_allocator_core_assert.svh
// assertion macros for the lock pool allocator core
// used by the controller and datapath modules, no other dependencies
`ifndef RESOURCE_LOCK_POOL_ALLOCATOR_CORE_ASSERT_SVH
`define RESOURCE_LOCK_POOL_ALLOCATOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define RLPA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define RLPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RLPA_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define RLPA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/core/rlpa_pkg.sv
// shared types, codes and the lowest-set-bit encoder of the lock pool allocator
// no dependencies
`timescale 1ns / 1ps

package rlpa_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int KIND_W      = 2;
    localparam int STAT_W      = 2;
    localparam int MOD_STEPS   = IDX_W;
    localparam int STEP_W      = $clog2(MOD_STEPS);
    localparam int GRP         = 8;
    localparam int NGRP        = MAX_ENTRIES / GRP;
    localparam int GRP_W       = $clog2(GRP);
    localparam int NGRP_W      = $clog2(NGRP);

    localparam logic [CNT_W-1:0] POOL_SIZE_RESET = CNT_W'(MAX_ENTRIES);
    localparam logic             REG_POOL_SIZE   = 1'b0;

    typedef enum logic [KIND_W-1:0] {
        K_ACQUIRE,
        K_RELEASE,
        K_QUERY,
        K_FIND_LOCKED
    } t_kind;

    typedef enum logic [STAT_W-1:0] {
        ST_OK,
        ST_NONE,
        ST_DOUBLE,
        ST_RANGE
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MOD,
        S_SCAN,
        S_PICK
    } t_state;

    typedef struct packed {
        logic load;
        logic mod_step;
        logic mod_last;
        logic scan;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic hint_ge_size;
        logic out_busy;
    } t_stat;

    typedef struct packed {
        logic             any;
        logic [IDX_W-1:0] idx;
    } t_enc;

    // two-level search: first non-empty group, then first bit inside it
    function automatic t_enc lowest_set(input logic [MAX_ENTRIES-1:0] v);
        logic [NGRP-1:0]   grp_any;
        logic [NGRP_W-1:0] gsel;
        logic [GRP-1:0]    grp_v;
        logic [GRP_W-1:0]  bsel;
        t_enc              r;
        for (int g = 0; g < NGRP; g++) begin
            grp_any[g] = |v[g*GRP +: GRP];
        end
        gsel = '0;
        for (int g = NGRP - 1; g >= 0; g--) begin
            if (grp_any[g]) begin
                gsel = NGRP_W'(g);
            end
        end
        grp_v = v[gsel*GRP +: GRP];
        bsel  = '0;
        for (int b = GRP - 1; b >= 0; b--) begin
            if (grp_v[b]) begin
                bsel = GRP_W'(b);
            end
        end
        r.any = |grp_any;
        r.idx = {gsel, bsel};
        return r;
    endfunction

endpackage

>>> rtl/core/resource_lock_pool_allocator_core.sv
// channel     | direction | handshake          | payload
// input item  | in        | i_valid / o_stall  | i_kind, i_index, i_start_hint
// result item | out       | o_valid / i_stall  | o_status, o_found_index, o_is_free,
//             |           |                    | o_locked_count
// config      | in        | psel/penable/pwrite| paddr, pwdata, prdata, pready
//
// one item at a time; an acquire whose hint is at or above the pool size first takes
// 6 remainder steps, one hint bit per cycle, before the search
// the result register lets the next item be taken while a result waits; a stalled
// result holds the item in its commit state until the output is free
// synchronous active-low reset: all entries free, count zero, pool size 64
// top level of the lock pool allocator; uses rlpa_pkg, rlpa_ctrl and rlpa_dp
`timescale 1ns / 1ps

module resource_lock_pool_allocator_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [rlpa_pkg::KIND_W-1:0] i_kind,
    input  logic [rlpa_pkg::IDX_W-1:0]  i_index,
    input  logic [rlpa_pkg::IDX_W-1:0]  i_start_hint,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [rlpa_pkg::STAT_W-1:0] o_status,
    output logic [rlpa_pkg::IDX_W-1:0]  o_found_index,
    output logic                        o_is_free,
    output logic [rlpa_pkg::CNT_W-1:0]  o_locked_count,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    logic [rlpa_pkg::CNT_W-1:0] r_pool_size;
    logic [rlpa_pkg::CNT_W-1:0] size;
    rlpa_pkg::t_cmd             cmd;
    rlpa_pkg::t_stat            stat;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_size <= rlpa_pkg::POOL_SIZE_RESET;
        end else if (psel && penable && pwrite && paddr[2] == rlpa_pkg::REG_POOL_SIZE) begin
            r_pool_size <= pwdata[rlpa_pkg::CNT_W-1:0];
        end
    end

    always_comb begin
        if (paddr[2] == rlpa_pkg::REG_POOL_SIZE) begin
            prdata = {{(32 - rlpa_pkg::CNT_W){1'b0}}, r_pool_size};
        end else begin
            prdata = '0;
        end
    end

    // a written zero acts as one entry, anything past the pool as the full pool
    always_comb begin
        if (r_pool_size == '0) begin
            size = rlpa_pkg::CNT_W'(1);
        end else if (r_pool_size > rlpa_pkg::CNT_W'(rlpa_pkg::MAX_ENTRIES)) begin
            size = rlpa_pkg::CNT_W'(rlpa_pkg::MAX_ENTRIES);
        end else begin
            size = r_pool_size;
        end
    end

    rlpa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_kind  (i_kind),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    rlpa_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_kind         (i_kind),
        .i_index        (i_index),
        .i_start_hint   (i_start_hint),
        .i_size         (size),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_found_index  (o_found_index),
        .o_is_free      (o_is_free),
        .o_locked_count (o_locked_count)
    );

endmodule

>>> rtl/core/rlpa_dp.sv
// datapath of the lock pool allocator: free bitmap, locked count, remainder unit,
// candidate search and output register; uses rlpa_pkg and the assertion header
`timescale 1ns / 1ps
`include "resource_lock_pool_allocator_core_assert.svh"

module rlpa_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  rlpa_pkg::t_cmd                   i_cmd,
    output rlpa_pkg::t_stat                  o_stat,
    input  logic [rlpa_pkg::KIND_W-1:0]      i_kind,
    input  logic [rlpa_pkg::IDX_W-1:0]       i_index,
    input  logic [rlpa_pkg::IDX_W-1:0]       i_start_hint,
    input  logic [rlpa_pkg::CNT_W-1:0]       i_size,
    input  logic                             i_stall,
    output logic                             o_valid,
    output logic [rlpa_pkg::STAT_W-1:0]      o_status,
    output logic [rlpa_pkg::IDX_W-1:0]       o_found_index,
    output logic                             o_is_free,
    output logic [rlpa_pkg::CNT_W-1:0]       o_locked_count
);

    logic [rlpa_pkg::MAX_ENTRIES-1:0] r_free;
    logic [rlpa_pkg::CNT_W-1:0]       r_count;
    rlpa_pkg::t_kind                  r_kind;
    logic [rlpa_pkg::IDX_W-1:0]       r_idx;
    logic [rlpa_pkg::IDX_W-1:0]       r_p;
    logic [rlpa_pkg::IDX_W-1:0]       r_rem;
    logic [rlpa_pkg::MAX_ENTRIES-1:0] r_sel;
    logic                             r_valid;
    logic [rlpa_pkg::STAT_W-1:0]      r_status;
    logic [rlpa_pkg::IDX_W-1:0]       r_found;
    logic                             r_is_free;
    logic [rlpa_pkg::CNT_W-1:0]       r_out_count;

    logic [rlpa_pkg::CNT_W-1:0]       rem_sh;
    logic [rlpa_pkg::CNT_W-1:0]       n_rem;
    logic [rlpa_pkg::MAX_ENTRIES-1:0] act_mask;
    logic [rlpa_pkg::MAX_ENTRIES-1:0] gt_mask;
    logic [rlpa_pkg::MAX_ENTRIES-1:0] cand_all;
    logic [rlpa_pkg::MAX_ENTRIES-1:0] cand_hi;
    logic [rlpa_pkg::MAX_ENTRIES-1:0] cand_lock;
    logic [rlpa_pkg::MAX_ENTRIES-1:0] n_sel;
    rlpa_pkg::t_enc                   enc;
    logic                             idx_in;
    logic [rlpa_pkg::MAX_ENTRIES-1:0] n_free;
    logic [rlpa_pkg::CNT_W-1:0]       n_count;
    rlpa_pkg::t_status                n_status;
    logic [rlpa_pkg::IDX_W-1:0]       n_found;
    logic                             n_is_free;

    assign o_stat.hint_ge_size = {1'b0, i_start_hint} >= i_size;
    assign o_stat.out_busy     = r_valid & i_stall;

    // restoring remainder, one hint bit per step, msb first
    always_comb begin
        rem_sh = {r_rem, r_p[rlpa_pkg::IDX_W-1]};
        n_rem  = (rem_sh >= i_size) ? (rem_sh - i_size) : rem_sh;
    end

    always_comb begin
        for (int i = 0; i < rlpa_pkg::MAX_ENTRIES; i++) begin
            act_mask[i] = rlpa_pkg::CNT_W'(i) < i_size;
            gt_mask[i]  = rlpa_pkg::IDX_W'(i) > r_p;
        end
        cand_all  = r_free & act_mask;
        cand_hi   = cand_all & gt_mask;
        cand_lock = ~r_free & act_mask;
        // acquire round robin: entries past the start, else wrap to the bottom
        if (r_kind == rlpa_pkg::K_FIND_LOCKED) begin
            n_sel = cand_lock;
        end else if (|cand_hi) begin
            n_sel = cand_hi;
        end else begin
            n_sel = cand_all;
        end
    end

    assign enc    = rlpa_pkg::lowest_set(r_sel);
    assign idx_in = {1'b0, r_idx} < i_size;

    always_comb begin
        n_free    = r_free;
        n_count   = r_count;
        n_status  = rlpa_pkg::ST_NONE;
        n_found   = '0;
        n_is_free = 1'b0;
        case (r_kind)
            rlpa_pkg::K_ACQUIRE: begin
                if (enc.any) begin
                    n_free[enc.idx] = 1'b0;
                    n_count         = r_count + 1'b1;
                    n_status        = rlpa_pkg::ST_OK;
                    n_found         = enc.idx;
                end
            end
            rlpa_pkg::K_RELEASE: begin
                if (!idx_in) begin
                    n_status = rlpa_pkg::ST_RANGE;
                end else if (r_free[r_idx]) begin
                    n_status = rlpa_pkg::ST_DOUBLE;
                end else begin
                    n_free[r_idx] = 1'b1;
                    if (r_count != '0) begin
                        n_count = r_count - 1'b1;
                    end
                    n_status = rlpa_pkg::ST_OK;
                end
            end
            rlpa_pkg::K_QUERY: begin
                if (!idx_in) begin
                    n_status = rlpa_pkg::ST_RANGE;
                end else begin
                    n_status  = rlpa_pkg::ST_OK;
                    n_is_free = r_free[r_idx];
                end
            end
            default: begin
                if (enc.any) begin
                    n_status = rlpa_pkg::ST_OK;
                    n_found  = enc.idx;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free  <= '1;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_free  <= n_free;
                r_count <= n_count;
                r_valid <= 1'b1;
            end else if (r_valid && !i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= rlpa_pkg::t_kind'(i_kind);
            r_idx  <= i_index;
            r_p    <= i_start_hint;
            r_rem  <= '0;
        end else if (i_cmd.mod_step) begin
            r_rem <= n_rem[rlpa_pkg::IDX_W-1:0];
            if (i_cmd.mod_last) begin
                r_p <= n_rem[rlpa_pkg::IDX_W-1:0];
            end else begin
                r_p <= {r_p[rlpa_pkg::IDX_W-2:0], 1'b0};
            end
        end
        if (i_cmd.scan) begin
            r_sel <= n_sel;
        end
        if (i_cmd.commit) begin
            r_status    <= n_status;
            r_found     <= n_found;
            r_is_free   <= n_is_free;
            r_out_count <= n_count;
        end
    end

    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_found_index  = r_found;
    assign o_is_free      = r_is_free;
    assign o_locked_count = r_out_count;

    `RLPA_ASSERT_IMPL(a_count_matches_map, i_clk, i_rst_n, 1'b1, $countones(~r_free) == r_count)
    `RLPA_ASSERT_NEXT(a_rem_below_size, i_clk, i_rst_n, i_cmd.mod_step, {1'b0, r_rem} < i_size)
    `RLPA_ASSERT_NEXT(a_commit_shows_item, i_clk, i_rst_n, i_cmd.commit, r_valid)

endmodule

>>> rtl/core/rlpa_ctrl.sv
// controller of the lock pool allocator: sequences load, remainder steps,
// search and commit; uses rlpa_pkg and the assertion header
`timescale 1ns / 1ps
`include "resource_lock_pool_allocator_core_assert.svh"

module rlpa_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [rlpa_pkg::KIND_W-1:0] i_kind,
    input  rlpa_pkg::t_stat             i_stat,
    output rlpa_pkg::t_cmd              o_cmd
);

    localparam logic [rlpa_pkg::STEP_W-1:0] LAST_STEP =
        rlpa_pkg::STEP_W'(rlpa_pkg::MOD_STEPS - 1);

    rlpa_pkg::t_state            r_state;
    rlpa_pkg::t_state            n_state;
    logic [rlpa_pkg::STEP_W-1:0] r_step;
    logic                        last_step;

    assign last_step = r_step == LAST_STEP;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rlpa_pkg::S_IDLE: begin
                if (i_valid) begin
                    // hint already below the size needs no remainder pass
                    if (rlpa_pkg::t_kind'(i_kind) == rlpa_pkg::K_ACQUIRE &&
                        i_stat.hint_ge_size) begin
                        n_state = rlpa_pkg::S_MOD;
                    end else begin
                        n_state = rlpa_pkg::S_SCAN;
                    end
                end
            end
            rlpa_pkg::S_MOD: begin
                if (last_step) begin
                    n_state = rlpa_pkg::S_SCAN;
                end
            end
            rlpa_pkg::S_SCAN: begin
                n_state = rlpa_pkg::S_PICK;
            end
            rlpa_pkg::S_PICK: begin
                if (!i_stat.out_busy) begin
                    n_state = rlpa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rlpa_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_stall        = r_state != rlpa_pkg::S_IDLE;
        o_cmd.load     = (r_state == rlpa_pkg::S_IDLE) && i_valid;
        o_cmd.mod_step = r_state == rlpa_pkg::S_MOD;
        o_cmd.mod_last = (r_state == rlpa_pkg::S_MOD) && last_step;
        o_cmd.scan     = r_state == rlpa_pkg::S_SCAN;
        o_cmd.commit   = (r_state == rlpa_pkg::S_PICK) && !i_stat.out_busy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rlpa_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else if (r_state == rlpa_pkg::S_MOD && !last_step) begin
            r_step <= r_step + 1'b1;
        end else begin
            r_step <= '0;
        end
    end

    `RLPA_ASSERT_NEXT(a_load_leaves_idle, i_clk, i_rst_n, o_cmd.load, r_state != rlpa_pkg::S_IDLE)
    `RLPA_ASSERT_NEXT(a_mod_ends_in_scan, i_clk, i_rst_n, o_cmd.mod_last, r_state == rlpa_pkg::S_SCAN)
    `RLPA_ASSERT_IMPL(a_step_idle_zero, i_clk, i_rst_n, r_state != rlpa_pkg::S_MOD, r_step == '0)

endmodule

>>> tb/sv/tb_resource_lock_pool_allocator_core.sv
// self-checking testbench for the lock pool allocator core: directed and random items
// checked against a bitmap predictor held in a small scoreboard class; uses rlpa_pkg
`timescale 1ns / 1ps

module tb_resource_lock_pool_allocator_core;
    import rlpa_pkg::*;

    localparam int          STUCK_LIMIT    = 4000;
    localparam int          HOLD_CYCLES    = 300;
    localparam int          SETTLE_CYCLES  = 16;
    localparam logic [2:0]  POOL_SIZE_ADDR = 3'(4 * int'(REG_POOL_SIZE));

    typedef struct {
        t_status          status;
        logic [IDX_W-1:0] found;
        logic             is_free;
        logic [CNT_W-1:0] count;
    } lock_result_t;

    class lock_pool_scoreboard;
        bit [MAX_ENTRIES-1:0] free_map;
        bit [CNT_W-1:0]       locked_total;
        bit [CNT_W-1:0]       pool_size;
        lock_result_t         pending_results[$];
        int                   errors;

        function new();
            free_map     = '1;
            locked_total = '0;
            pool_size    = POOL_SIZE_RESET;
            errors       = 0;
        endfunction

        function void set_size(bit [CNT_W-1:0] value);
            pool_size = value;
        endfunction

        // written 0 acts as 1, anything above the pool acts as the full pool
        function int active_size();
            if (pool_size < 1) begin
                return 1;
            end
            if (pool_size > MAX_ENTRIES) begin
                return MAX_ENTRIES;
            end
            return int'(pool_size);
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function int pick_locked(int start);
            int size;
            int j;
            size = active_size();
            for (int i = 0; i < size; i++) begin
                j = (start + i) % size;
                if (!free_map[j]) begin
                    return j;
                end
            end
            return -1;
        endfunction

        function void predict_item(t_kind kind, bit [IDX_W-1:0] idx, bit [IDX_W-1:0] hint);
            int           size;
            int           p;
            lock_result_t r;
            size      = active_size();
            r.status  = ST_NONE;
            r.found   = '0;
            r.is_free = 1'b0;
            case (kind)
                K_ACQUIRE: begin
                    // round-robin search starts one past the hint
                    p = int'(hint) % size;
                    for (int i = 0; i < size; i++) begin
                        p = (p + 1) % size;
                        if (free_map[p]) begin
                            free_map[p]  = 1'b0;
                            locked_total = locked_total + 1'b1;
                            r.status     = ST_OK;
                            r.found      = IDX_W'(p);
                            break;
                        end
                    end
                end
                K_RELEASE: begin
                    if (int'(idx) >= size) begin
                        r.status = ST_RANGE;
                    end else if (free_map[idx]) begin
                        r.status = ST_DOUBLE;
                    end else begin
                        free_map[idx] = 1'b1;
                        if (locked_total > 0) begin
                            locked_total = locked_total - 1'b1;
                        end
                        r.status = ST_OK;
                    end
                end
                K_QUERY: begin
                    if (int'(idx) >= size) begin
                        r.status = ST_RANGE;
                    end else begin
                        r.status  = ST_OK;
                        r.is_free = free_map[idx];
                    end
                end
                default: begin
                    for (int i = 0; i < size; i++) begin
                        if (!free_map[i]) begin
                            r.status = ST_OK;
                            r.found  = IDX_W'(i);
                            break;
                        end
                    end
                end
            endcase
            r.count = locked_total;
            pending_results.push_back(r);
        endfunction

        function void check_result(logic [STAT_W-1:0] status, logic [IDX_W-1:0] found,
                                   logic is_free, logic [CNT_W-1:0] count);
            lock_result_t e;
            if (pending_results.size() == 0) begin
                $error("result item with nothing expected: status %0d", status);
                errors++;
                return;
            end
            e = pending_results.pop_front();
            if (status !== e.status) begin
                $error("status: expected %0d, actual %0d", e.status, status);
                errors++;
            end
            if (found !== e.found) begin
                $error("found_index: expected %0d, actual %0d", e.found, found);
                errors++;
            end
            if (is_free !== e.is_free) begin
                $error("is_free: expected %0d, actual %0d", e.is_free, is_free);
                errors++;
            end
            if (count !== e.count) begin
                $error("locked_count: expected %0d, actual %0d", e.count, count);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [KIND_W-1:0]  i_kind;
    logic [IDX_W-1:0]   i_index;
    logic [IDX_W-1:0]   i_start_hint;
    logic               o_valid;
    logic               i_stall;
    logic [STAT_W-1:0]  o_status;
    logic [IDX_W-1:0]   o_found_index;
    logic               o_is_free;
    logic [CNT_W-1:0]   o_locked_count;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    lock_pool_scoreboard sb;
    int                  send_idle_pct;
    int                  recv_idle_pct;
    bit                  hold_req;
    int                  hold_left;
    int                  stuck_cycles;

    resource_lock_pool_allocator_core i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_kind         (i_kind),
        .i_index        (i_index),
        .i_start_hint   (i_start_hint),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_found_index  (o_found_index),
        .o_is_free      (o_is_free),
        .o_locked_count (o_locked_count),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // receiver: random stall, or a long hold-off when asked for one
    initial begin
        i_stall   = 1'b0;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                i_stall   = 1'b1;
                hold_left = hold_left - 1;
            end else begin
                i_stall = ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_result(o_status, o_found_index, o_is_free, o_locked_count);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                stuck_cycles <= 0;
            end else if (stuck_cycles >= STUCK_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end else begin
                stuck_cycles <= stuck_cycles + 1;
            end
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_request(t_kind kind, bit [IDX_W-1:0] idx, bit [IDX_W-1:0] hint);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid      = 1'b1;
        i_kind       = kind;
        i_index      = idx;
        i_start_hint = hint;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        sb.predict_item(kind, idx, hint);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_valid = 1'b0;
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_pool_size(bit [CNT_W-1:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = POOL_SIZE_ADDR;
        pwdata  = 32'(value);
        @(negedge i_clk);
        penable = 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        sb.set_size(value);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic run_phase(int n, int acq_pct, int rel_pct);
        int             size;
        int             r;
        int             pick;
        t_kind          kind;
        bit [IDX_W-1:0] idx;
        bit [IDX_W-1:0] hint;
        for (int k = 0; k < n; k++) begin
            size = sb.active_size();
            r    = $urandom_range(99);
            idx  = IDX_W'($urandom_range(63));
            hint = IDX_W'($urandom_range(63));
            if (r < acq_pct) begin
                kind = K_ACQUIRE;
            end else if (r < acq_pct + rel_pct) begin
                kind = K_RELEASE;
                // mostly release something that is held, the rest is noise
                if ($urandom_range(9) < 7) begin
                    pick = sb.pick_locked($urandom_range(63));
                    if (pick >= 0) begin
                        idx = IDX_W'(pick);
                    end
                end
            end else if ($urandom_range(1) == 1) begin
                kind = K_QUERY;
                if ($urandom_range(3) != 0) begin
                    idx = IDX_W'($urandom_range(size - 1));
                end
            end else begin
                kind = K_FIND_LOCKED;
            end
            send_request(kind, idx, hint);
        end
    endtask

    initial begin
        int sizes[12];
        int value;
        sizes         = '{64, 8, 127, 2, 0, 1, 100, 0, 16, 0, 64, 5};
        sb            = new();
        stuck_cycles  = 0;
        hold_req      = 1'b0;
        send_idle_pct = 11;
        recv_idle_pct = 51;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_kind        = K_ACQUIRE;
        i_index       = '0;
        i_start_hint  = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // full pool after reset
        send_request(K_FIND_LOCKED, 6'd0, 6'd0);
        send_request(K_QUERY, 6'd0, 6'd0);
        send_request(K_QUERY, 6'd63, 6'd63);
        send_request(K_RELEASE, 6'd5, 6'd0);
        send_request(K_ACQUIRE, 6'd0, 6'd63);
        send_request(K_ACQUIRE, 6'd63, 6'd0);
        send_request(K_FIND_LOCKED, 6'd0, 6'd0);
        send_request(K_RELEASE, 6'd0, 6'd0);
        send_request(K_RELEASE, 6'd0, 6'd0);
        send_request(K_QUERY, 6'd0, 6'd0);
        send_request(K_ACQUIRE, 6'd0, 6'd62);
        send_request(K_QUERY, 6'd63, 6'd0);
        send_request(K_FIND_LOCKED, 6'd0, 6'd0);

        // single-entry pool: entries above it stay counted
        drain_results();
        write_pool_size(7'd1);
        send_request(K_ACQUIRE, 6'd0, 6'd63);
        send_request(K_ACQUIRE, 6'd21, 6'd42);
        send_request(K_RELEASE, 6'd1, 6'd0);
        send_request(K_QUERY, 6'd1, 6'd0);
        send_request(K_QUERY, 6'd0, 6'd0);
        send_request(K_FIND_LOCKED, 6'd0, 6'd0);
        send_request(K_RELEASE, 6'd63, 6'd0);
        drain_results();
        write_pool_size(7'd0);
        send_request(K_ACQUIRE, 6'd0, 6'd0);
        drain_results();
        write_pool_size(7'd127);
        send_request(K_FIND_LOCKED, 6'd0, 6'd0);

        for (int ph = 0; ph < 12; ph++) begin
            drain_results();
            value = (ph == 4 || ph == 9) ? $urandom_range(64, 1) : sizes[ph];
            write_pool_size(CNT_W'(value));
            case (ph / 4)
                0: begin
                    send_idle_pct = 11;
                    recv_idle_pct = 51;
                end
                1: begin
                    send_idle_pct = 51;
                    recv_idle_pct = 11;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            if (ph == 1 || ph == 7 || ph == 10) begin
                @(posedge i_clk);
                hold_req = 1'b1;
                @(negedge i_clk);
            end
            if (ph % 2 == 0) begin
                run_phase(104, 55, 20);
            end else begin
                run_phase(104, 25, 50);
            end
        end

        drain_results();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
